/* src/nearest_polyline_segment_assert.svh */
`ifndef NEAREST_POLYLINE_SEGMENT_ASSERT_SVH
`define NEAREST_POLYLINE_SEGMENT_ASSERT_SVH

// check a property on every clock edge outside reset
`define NPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define NPS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

/* src/nps_pkg.sv */
package nps_pkg;

  localparam int MAG_W  = 33;
  localparam int PROD_W = 2 * MAG_W;
  localparam int ACC_W  = 68;
  localparam int ROOT_W = ACC_W / 2;
  localparam int LEN_W  = ROOT_W + 1;
  localparam int Q_W    = 36;
  localparam int PROJ_W = Q_W + 1;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  function automatic logic [MAG_W-1:0] mag33(input logic signed [MAG_W-1:0] v);
    mag33 = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

/* src/nps_ram.sv */
module nps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/nps_mul.sv */
module nps_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [nps_pkg::MAG_W-1:0]  a,
  input  logic [nps_pkg::MAG_W-1:0]  b,
  output logic                       done,
  output logic [nps_pkg::PROD_W-1:0] prod
);
  import nps_pkg::*;

  logic [MAG_W-1:0] a_r;
  logic [5:0]       cnt;
  logic             run;
  logic [MAG_W:0]   sum;

  assign sum = {1'b0, prod[PROD_W-1:MAG_W]} + (prod[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go && !run) begin
        run  <= 1'b1;
        a_r  <= a;
        prod <= {{MAG_W{1'b0}}, b};
        cnt  <= '0;
      end else if (run) begin
        prod <= {sum, prod[MAG_W-1:1]};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'(MAG_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/nps_sqrt.sv */
module nps_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [nps_pkg::ACC_W-1:0]  val,
  output logic                       done,
  output logic [nps_pkg::ROOT_W-1:0] root
);
  import nps_pkg::*;

  logic [ACC_W-1:0]  v_r;
  logic [ROOT_W+3:0] rem;
  logic [ROOT_W+3:0] rem2;
  logic [ROOT_W+3:0] trial;
  logic [5:0]        cnt;
  logic              run;

  assign rem2  = {rem[ROOT_W+1:0], v_r[ACC_W-1:ACC_W-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go && !run) begin
        run  <= 1'b1;
        v_r  <= val;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (run) begin
        v_r <= {v_r[ACC_W-3:0], 2'b00};
        if (rem2 >= trial) begin
          rem  <= rem2 - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem2;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(ROOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/nps_div.sv */
module nps_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [nps_pkg::ACC_W-1:0] num,
  input  logic [nps_pkg::LEN_W-1:0] den,
  output logic                      done,
  output logic [nps_pkg::Q_W-1:0]   quo
);
  import nps_pkg::*;

  logic [ACC_W-1:0] n_r;
  logic [LEN_W-1:0] d_r;
  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   r2;
  logic [6:0]       cnt;
  logic             run;

  assign r2 = {rem, n_r[ACC_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go && !run) begin
        run <= 1'b1;
        n_r <= num;
        d_r <= den;
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end else if (run) begin
        n_r <= {n_r[ACC_W-2:0], 1'b0};
        if (r2 >= {1'b0, d_r}) begin
          rem <= LEN_W'(r2 - {1'b0, d_r});
          quo <= {quo[Q_W-2:0], 1'b1};
        end else begin
          rem <= LEN_W'(r2);
          quo <= {quo[Q_W-2:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(ACC_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/nearest_polyline_segment.sv */
// Append and clear items are taken while idle and raise no busy.
// A query holds busy while it loads the first point, works through each segment and
// the last point with the bit-serial multiply, square root and divide units.
// The result strobe comes in the cycle after the last busy cycle.
// Reset empties the store (contents unspecified) and returns to idle.
module nearest_polyline_segment #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  output logic               done,
  output logic               found,
  output logic [7:0]         segment_id,
  output logic signed [31:0] start_x,
  output logic signed [31:0] start_y,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y,
  output logic [31:0]        perp_distance,
  output logic signed [31:0] projection
);
  import nps_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] OP_DXDX = 3'd0;
  localparam logic [2:0] OP_DYDY = 3'd1;
  localparam logic [2:0] OP_RXDX = 3'd2;
  localparam logic [2:0] OP_RYDY = 3'd3;
  localparam logic [2:0] OP_RYDX = 3'd4;
  localparam logic [2:0] OP_RXDY = 3'd5;
  localparam logic [2:0] OP_RXRX = 3'd6;
  localparam logic [2:0] OP_RYRY = 3'd7;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_LD   = 11'b00000000100,
    S_MUL  = 11'b00000001000,
    S_SQL  = 11'b00000010000,
    S_DVP  = 11'b00000100000,
    S_DVD  = 11'b00001000000,
    S_SQP  = 11'b00010000000,
    S_EVAL = 11'b00100000000,
    S_FIN  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state;

  logic [CW-1:0]       cnt;
  logic [CW-1:0]       idx;
  logic signed [31:0]  vx, vy, px, py, ex, ey;
  logic [2:0]          op;
  logic                issued;
  logic                final_pass;
  logic signed [ACC_W-1:0] len_acc, dot, crs, rr;
  logic [LEN_W-1:0]    len;
  logic signed [PROJ_W-1:0] proj;
  logic [Q_W-1:0]      seg_dist;
  logic [ROOT_W-1:0]   pd;
  logic [Q_W-1:0]      best;
  logic                best_ok;

  logic                ram_we;
  logic [63:0]         rdata;

  logic signed [MAG_W-1:0] dx, dy, rx, ry;
  logic [MAG_W-1:0]    dxm, dym, rxm, rym;
  logic [MAG_W-1:0]    ma, mb;
  logic                pneg;
  logic                mul_go, mul_done, sq_go, sq_done, div_go, div_done;
  logic [PROD_W-1:0]   prod;
  logic [ROOT_W-1:0]   root;
  logic [Q_W-1:0]      quo;
  logic [ACC_W-1:0]    pe, sq_val, div_num;
  logic signed [PROJ_W-1:0] len_s;
  logic                in_seg, c1, c2, ok1;
  logic [Q_W-1:0]      b1;
  logic [CW-1:0]       idx_next;

  assign busy = !state[0];

  assign ram_we = (state == S_IDLE) && start && (kind == KIND_APPEND) &&
                  (cnt < CW'(MAX_POINTS));

  nps_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata ({pos_x, pos_y}),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign dx  = {ex[31], ex} - {px[31], px};
  assign dy  = {ey[31], ey} - {py[31], py};
  assign rx  = {vx[31], vx} - {px[31], px};
  assign ry  = {vy[31], vy} - {py[31], py};
  assign dxm = mag33(dx);
  assign dym = mag33(dy);
  assign rxm = mag33(rx);
  assign rym = mag33(ry);

  always_comb begin
    case (op)
      OP_DXDX: begin ma = dxm; mb = dxm; pneg = 1'b0; end
      OP_DYDY: begin ma = dym; mb = dym; pneg = 1'b0; end
      OP_RXDX: begin ma = rxm; mb = dxm; pneg = rx[MAG_W-1] ^ dx[MAG_W-1]; end
      OP_RYDY: begin ma = rym; mb = dym; pneg = ry[MAG_W-1] ^ dy[MAG_W-1]; end
      OP_RYDX: begin ma = rym; mb = dxm; pneg = ry[MAG_W-1] ^ dx[MAG_W-1]; end
      OP_RXDY: begin ma = rxm; mb = dym; pneg = ~(rx[MAG_W-1] ^ dy[MAG_W-1]); end
      OP_RXRX: begin ma = rxm; mb = rxm; pneg = 1'b0; end
      default: begin ma = rym; mb = rym; pneg = 1'b0; end
    endcase
  end

  assign pe = pneg ? ACC_W'(-{2'b00, prod}) : {2'b00, prod};

  assign mul_go  = (state == S_MUL) && !issued;
  assign sq_go   = ((state == S_SQL) || (state == S_SQP)) && !issued;
  assign div_go  = ((state == S_DVP) || (state == S_DVD)) && !issued;
  assign sq_val  = (state == S_SQL) ? len_acc : rr;
  assign div_num = (state == S_DVP) ? (dot[ACC_W-1] ? ACC_W'(-dot) : dot)
                                    : (crs[ACC_W-1] ? ACC_W'(-crs) : crs);

  nps_mul u_mul (
    .clk (clk), .rst (rst), .go (mul_go), .a (ma), .b (mb),
    .done (mul_done), .prod (prod)
  );

  nps_sqrt u_sqrt (
    .clk (clk), .rst (rst), .go (sq_go), .val (sq_val),
    .done (sq_done), .root (root)
  );

  nps_div u_div (
    .clk (clk), .rst (rst), .go (div_go), .num (div_num), .den (len),
    .done (div_done), .quo (quo)
  );

  assign len_s    = {2'b00, len};
  assign in_seg   = !proj[PROJ_W-1] && (proj != '0) && (proj < len_s);
  assign c1       = in_seg && (!best_ok || (seg_dist < best));
  assign b1       = c1 ? seg_dist : best;
  assign ok1      = best_ok || c1;
  assign c2       = !ok1 || ({2'b00, pd} < b1);
  assign idx_next = idx + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      done   <= 1'b0;
      issued <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      if (mul_go || sq_go || div_go) begin
        issued <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            case (kind)
              KIND_APPEND: begin
                if (cnt < CW'(MAX_POINTS)) begin
                  cnt <= cnt + CW'(1);
                end
              end
              KIND_CLEAR: begin
                cnt <= '0;
              end
              KIND_QUERY: begin
                vx         <= pos_x;
                vy         <= pos_y;
                idx        <= '0;
                best_ok    <= 1'b0;
                final_pass <= 1'b0;
                found      <= (cnt != '0);
                segment_id <= '0;
                start_x    <= '0;
                start_y    <= '0;
                end_x      <= '0;
                end_y      <= '0;
                perp_distance <= '0;
                projection <= '0;
                state      <= (cnt == '0) ? S_OUT : S_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          if (idx == '0) begin
            px  <= rdata[63:32];
            py  <= rdata[31:0];
            idx <= CW'(1);
            state <= (cnt == CW'(1)) ? S_FIN : S_RD;
          end else begin
            ex      <= rdata[63:32];
            ey      <= rdata[31:0];
            len_acc <= '0;
            dot     <= '0;
            crs     <= '0;
            rr      <= '0;
            op      <= OP_DXDX;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            issued <= 1'b0;
            case (op)
              OP_DXDX, OP_DYDY: len_acc <= len_acc + pe;
              OP_RXDX, OP_RYDY: dot <= dot + pe;
              OP_RYDX, OP_RXDY: crs <= crs + pe;
              default:          rr <= rr + pe;
            endcase
            op <= op + 3'd1;
            if (op == OP_RYRY) begin
              state <= final_pass ? S_SQP : S_SQL;
            end
          end
        end
        S_SQL: begin
          if (sq_done) begin
            issued   <= 1'b0;
            len      <= {1'b0, root};
            proj     <= '0;
            seg_dist <= '0;
            state    <= (root == '0) ? S_SQP : S_DVP;
          end
        end
        S_DVP: begin
          if (div_done) begin
            issued <= 1'b0;
            proj   <= dot[ACC_W-1] ? PROJ_W'(-{1'b0, quo}) : {1'b0, quo};
            state  <= S_DVD;
          end
        end
        S_DVD: begin
          if (div_done) begin
            issued   <= 1'b0;
            seg_dist <= quo;
            state    <= S_SQP;
          end
        end
        S_SQP: begin
          if (sq_done) begin
            issued <= 1'b0;
            pd     <= root;
            state  <= final_pass ? S_FIN : S_EVAL;
          end
        end
        S_EVAL: begin
          best_ok <= 1'b1;
          best    <= c2 ? {2'b00, pd} : b1;
          if (c1 || c2) begin
            segment_id <= 8'(idx);
            start_x    <= px;
            start_y    <= py;
            end_x      <= ex;
            end_y      <= ey;
            perp_distance <= (seg_dist[Q_W-1:32] != '0) ? 32'hFFFFFFFF : seg_dist[31:0];
            if (proj[PROJ_W-1:31] == '0 || proj[PROJ_W-1:31] == '1) begin
              projection <= proj[31:0];
            end else begin
              projection <= proj[PROJ_W-1] ? 32'h80000000 : 32'h7FFFFFFF;
            end
          end
          px  <= ex;
          py  <= ey;
          idx <= idx_next;
          if (idx_next == cnt) begin
            final_pass <= 1'b1;
            rr         <= '0;
            op         <= OP_RXRX;
            state      <= S_MUL;
          end else begin
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (cnt == CW'(1) || ({2'b00, pd} < best)) begin
            segment_id    <= 8'(cnt - CW'(1));
            start_x       <= vx;
            start_y       <= vy;
            end_x         <= px;
            end_y         <= py;
            perp_distance <= '0;
            projection    <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "nearest_polyline_segment_assert.svh"

  `NPS_ASSERT(a_done_idle, !done || !busy, "result strobe while busy")
  `NPS_ASSERT(a_cnt_max, cnt <= CW'(MAX_POINTS), "point count above store depth")
  `NPS_ASSERT_NEXT(a_query_busy, start && !busy && kind == KIND_QUERY, busy, "query not taken")

endmodule

/* dv/tb.sv */
module tb;
  import nps_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    int                 gap;
  } cmd_t;

  typedef struct {
    logic               found;
    logic [7:0]         seg;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic [31:0]        perp;
    logic signed [31:0] proj;
  } seg_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind = KIND_APPEND;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic               done;
  logic               found;
  logic [7:0]         segment_id;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic [31:0]        perp_distance;
  logic signed [31:0] projection;

  nearest_polyline_segment DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .pos_x(pos_x), .pos_y(pos_y), .done(done), .found(found),
    .segment_id(segment_id), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .perp_distance(perp_distance),
    .projection(projection)
  );

  always #5 clk = ~clk;

  cmd_t               cmd_q[$];
  seg_t               nearest_q[$];
  logic signed [31:0] path_x[256];
  logic signed [31:0] path_y[256];
  int                 path_len = 0;
  int                 idle_cnt = 0;
  int                 mismatches = 0;
  int                 queries_seen = 0;
  int                 appends_done = 0;
  int                 max_len_seen = 0;
  logic               in_burst = 1'b0;

  function automatic logic [127:0] root128(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] hyp(input logic signed [127:0] a,
                                       input logic signed [127:0] b);
    logic signed [127:0] s;
    s = a * a + b * b;
    return root128(s);
  endfunction

  function automatic seg_t make_seg(input int id, input logic signed [127:0] ax,
      input logic signed [127:0] ay, input logic signed [127:0] bx,
      input logic signed [127:0] by, input logic [127:0] d,
      input logic signed [127:0] p);
    seg_t s;
    s.found = 1'b1;
    s.seg   = id[7:0];
    s.sx    = ax[31:0];
    s.sy    = ay[31:0];
    s.ex    = bx[31:0];
    s.ey    = by[31:0];
    s.perp  = (d > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    if (p > 128'sd2147483647) s.proj = 32'sh7FFF_FFFF;
    else if (p < -128'sd2147483648) s.proj = 32'sh8000_0000;
    else s.proj = p[31:0];
    return s;
  endfunction

  function automatic seg_t predict_query(input logic signed [31:0] qx,
                                         input logic signed [31:0] qy);
    seg_t               res;
    logic signed [127:0] vx, vy, ax, ay, bx, by, dx, dy, rx, ry, lens, proj, cr;
    logic [127:0]        len, sdist, pd, best;
    logic                better;
    res = '{default: '0};
    if (path_len == 0) return res;
    vx = qx; vy = qy;
    ax = path_x[0]; ay = path_y[0];
    best = 128'hFFFF_FFFF_FFFF_FFFF;
    for (int i = 1; i < path_len; i++) begin
      bx = path_x[i]; by = path_y[i];
      dx = bx - ax; dy = by - ay; rx = vx - ax; ry = vy - ay;
      len = hyp(dx, dy);
      lens = len;
      proj = 0; sdist = 0; better = 1'b0;
      if (len != 0) begin
        proj = (rx * dx + ry * dy) / lens;
        cr = (ry * dx - rx * dy) / lens;
        sdist = (cr < 0) ? -cr : cr;
      end
      if (proj > 0 && proj < lens && sdist < best) begin
        best = sdist;
        better = 1'b1;
      end
      pd = hyp(rx, ry);
      if (pd < best) begin
        best = pd;
        better = 1'b1;
      end
      if (better) res = make_seg(i, ax, ay, bx, by, sdist, proj);
      ax = bx; ay = by;
    end
    if (path_len == 1 || hyp(ax - vx, ay - vy) < best)
      res = make_seg(path_len - 1, vx, vy, ax, ay, 0, 0);
    return res;
  endfunction

  task automatic apply_item(input logic [1:0] k, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    case (k)
      KIND_APPEND: begin
        if (path_len < 256) begin
          path_x[path_len] = x;
          path_y[path_len] = y;
          path_len++;
        end
        appends_done++;
      end
      KIND_CLEAR: path_len = 0;
      KIND_QUERY: begin
        nearest_q.push_back(predict_query(x, y));
        if (path_len > max_len_seen) max_len_seen = path_len;
      end
      default: ;
    endcase
  endtask

  task automatic load_next();
    cmd_t c;
    c = cmd_q.pop_front();
    start <= 1'b1;
    kind  <= c.kind;
    pos_x <= c.x;
    pos_y <= c.y;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_cnt <= 0;
    end else if (start && !busy) begin
      apply_item(kind, pos_x, pos_y);
      if (cmd_q.size() > 0 && cmd_q[0].gap == 0) load_next();
      else start <= 1'b0;
      idle_cnt <= 0;
    end else if (!start && cmd_q.size() > 0) begin
      if (idle_cnt >= cmd_q[0].gap) begin
        load_next();
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    seg_t e;
    if (!rst && done) begin
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result seg %0d", segment_id);
      end else begin
        e = nearest_q.pop_front();
        queries_seen++;
        if (found !== e.found || segment_id !== e.seg || start_x !== e.sx ||
            start_y !== e.sy || end_x !== e.ex || end_y !== e.ey ||
            perp_distance !== e.perp || projection !== e.proj) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("query %0d exp f=%0d id=%0d s=(%0d,%0d) e=(%0d,%0d) d=%0d p=%0d",
                     queries_seen, e.found, e.seg, e.sx, e.sy, e.ex, e.ey, e.perp, e.proj);
            $display("query %0d got f=%0d id=%0d s=(%0d,%0d) e=(%0d,%0d) d=%0d p=%0d",
                     queries_seen, found, segment_id, start_x, start_y, end_x, end_y,
                     perp_distance, projection);
          end
        end
      end
    end
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
    if (in_burst) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic logic signed [31:0] draw_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endcase
  endfunction

  task automatic add_cmd(input logic [1:0] k, input logic signed [31:0] x,
                         input logic signed [31:0] y);
    cmd_t c;
    c.kind = k; c.x = x; c.y = y; c.gap = draw_gap();
    cmd_q.push_back(c);
  endtask

  initial begin
    int n_pts;
    int n_q;
    int rand_items;
    int rand_queries;
    add_cmd(KIND_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_cmd(KIND_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_cmd(KIND_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_cmd(KIND_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_cmd(KIND_QUERY, 0, 0);
    add_cmd(KIND_QUERY, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_cmd(2'd3, 32'sh1234_5678, 32'sh0000_0001);
    add_cmd(KIND_CLEAR, 0, 0);
    add_cmd(KIND_QUERY, 5, 5);
    add_cmd(KIND_APPEND, 32'sh0001_0000, 32'sh0001_0000);
    add_cmd(KIND_APPEND, 32'sh0001_0000, 32'sh0001_0000);
    add_cmd(KIND_APPEND, 32'sh0005_0000, 32'sh0001_0000);
    add_cmd(KIND_APPEND, 32'sh0005_0000, 32'sh0009_0000);
    add_cmd(KIND_QUERY, 32'sh0003_0000, 32'sh0003_0000);
    add_cmd(KIND_QUERY, 32'sh0001_0000, 32'sh0001_0000);
    add_cmd(KIND_QUERY, 32'sh0006_0000, 32'sh000A_0000);
    add_cmd(KIND_QUERY, 32'shFFF0_0000, 32'sh0002_0000);
    add_cmd(KIND_CLEAR, 0, 0);
    for (int i = 0; i < 40; i++)
      add_cmd(KIND_APPEND, $signed(i * 32'h0001_0000), $signed((i % 7) * 32'h0000_8000));
    add_cmd(KIND_QUERY, 32'sh0080_0000, 32'sh0001_0000);
    add_cmd(KIND_CLEAR, 0, 0);
    rand_items = 0;
    rand_queries = 0;
    while (rand_items < 40 || rand_queries < 15) begin
      if ($urandom_range(0, 7) == 0) begin
        add_cmd(2'($urandom_range(0, 3)), $urandom, $urandom);
        rand_items++;
      end else begin
        add_cmd(KIND_CLEAR, $urandom, $urandom);
        n_pts = $urandom_range(1, 6);
        for (int i = 0; i < n_pts; i++) add_cmd(KIND_APPEND, draw_coord(), draw_coord());
        n_q = $urandom_range(1, 3);
        for (int i = 0; i < n_q; i++) add_cmd(KIND_QUERY, draw_coord(), draw_coord());
        rand_items += 1 + n_pts + n_q;
        rand_queries += n_q;
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (cmd_q.size() > 0 || start || nearest_q.size() > 0);
    repeat (200) @(posedge clk);
    $display("checked %0d queries over %0d appends; longest polyline %0d points",
             queries_seen, appends_done, max_len_seen);
    $display("%0d result mismatches, %0d results outstanding", mismatches, nearest_q.size());
    if (mismatches == 0 && nearest_q.size() == 0)
      $display("nearest_polyline_segment: match");
    else
      $display("nearest_polyline_segment: mismatch");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("nearest_polyline_segment: mismatch");
    $finish;
  end
endmodule
